@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fsc_pkg.sv @@
// Types, constants and helper functions for the Fourier series coefficient unit.
// No dependencies.
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int K_W          = 6;
    localparam int CORDIC_STEPS = 16;
    localparam int XW           = 34;   // CORDIC vector, Q2.30 plus headroom
    localparam int ZW           = 33;   // angle residue, 2^-32 turn units
    localparam logic signed [XW-1:0] CORDIC_KINIT = XW'(652032874);

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [15:0] sample;
        logic               last_sample;
    } t_in_item;

    typedef struct packed {
        logic [K_W-1:0]     harmonic_index;
        logic signed [31:0] cosine_coefficient;
        logic signed [31:0] sine_coefficient;
        logic [62:0]        power;
        logic               samples_dropped;
        logic               last_harmonic;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_READ,
        S_PREP,
        S_ROT,
        S_TRIG,
        S_MAC,
        S_DIVA,
        S_DIVB,
        S_SQA,
        S_SQB,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic rd;
        logic prep;
        logic rot;
        logic trig;
        logic mac;
        logic clr_acc;
        logic div_load;
        logic div_step;
        logic div_sel_b;
        logic take_a;
        logic take_b;
        logic sq_a;
        logic sq_b;
        logic emit;
    } t_dp_cmd;

    function automatic logic [29:0] atan_turn(input logic [3:0] idx);
        logic [29:0] v;
        unique case (idx)
            4'd0:    v = 30'h20000000;
            4'd1:    v = 30'h12E4051E;
            4'd2:    v = 30'h09FB385B;
            4'd3:    v = 30'h051111D4;
            4'd4:    v = 30'h028B0D43;
            4'd5:    v = 30'h0145D7E1;
            4'd6:    v = 30'h00A2F61E;
            4'd7:    v = 30'h00517C55;
            4'd8:    v = 30'h0028BE53;
            4'd9:    v = 30'h00145F2F;
            4'd10:   v = 30'h000A2F98;
            4'd11:   v = 30'h000517CC;
            4'd12:   v = 30'h00028BE6;
            4'd13:   v = 30'h000145F3;
            4'd14:   v = 30'h0000A2FA;
            4'd15:   v = 30'h0000517D;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/fsc_ctrl.sv @@
// Sequencer for sample loading and per-harmonic computation.
// Uses fsc_pkg.
`timescale 1ns / 1ps

module fsc_ctrl #(
    parameter int MAX_SAMPLES = 128,
    parameter int CNT_W       = 8,
    parameter int IDX_W       = 7,
    parameter int NW          = 38,
    parameter int SW          = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_last,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    output fsc_pkg::t_dp_cmd      o_cmd,
    output logic [IDX_W-1:0]      o_wr_addr,
    output logic [IDX_W-1:0]      o_rd_addr,
    output logic [fsc_pkg::K_W-1:0] o_k,
    output logic [3:0]            o_iter,
    output logic [CNT_W-1:0]      o_m,
    output logic                  o_run_ovf,
    output logic                  o_last_h
);

    fsc_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]        r_count, r_m, r_half, cnt_inc;
    logic                    r_ovf, r_run_ovf, r_out_valid;
    logic [IDX_W-1:0]        r_j;
    logic [fsc_pkg::K_W-1:0] r_k;
    logic [SW-1:0]           r_step;
    logic                    in_acc, full, j_last, rot_last, div_last, emit_ok, last_h;

    assign full     = (r_count == CNT_W'(MAX_SAMPLES));
    assign cnt_inc  = full ? r_count : r_count + 1'b1;
    assign in_acc   = i_valid && (r_state == fsc_pkg::S_LOAD);
    assign j_last   = ((CNT_W+1)'(r_j) + 1'b1 == (CNT_W+1)'(r_m));
    assign rot_last = (r_step == SW'(fsc_pkg::CORDIC_STEPS - 1));
    assign div_last = (r_step == SW'(NW));
    assign emit_ok  = !r_out_valid || !i_stall;
    assign last_h   = ((CNT_W+fsc_pkg::K_W)'(r_k) + 1'b1
                       == (CNT_W+fsc_pkg::K_W)'(r_half));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsc_pkg::S_LOAD: begin
                if (in_acc && i_last && (cnt_inc >> 1) != '0) n_state = fsc_pkg::S_READ;
            end
            fsc_pkg::S_READ: n_state = fsc_pkg::S_PREP;
            fsc_pkg::S_PREP: n_state = fsc_pkg::S_ROT;
            fsc_pkg::S_ROT: begin
                if (rot_last) n_state = fsc_pkg::S_TRIG;
            end
            fsc_pkg::S_TRIG: n_state = fsc_pkg::S_MAC;
            fsc_pkg::S_MAC:  n_state = j_last ? fsc_pkg::S_DIVA : fsc_pkg::S_READ;
            fsc_pkg::S_DIVA: begin
                if (div_last) n_state = fsc_pkg::S_DIVB;
            end
            fsc_pkg::S_DIVB: begin
                if (div_last) n_state = fsc_pkg::S_SQA;
            end
            fsc_pkg::S_SQA: n_state = fsc_pkg::S_SQB;
            fsc_pkg::S_SQB: n_state = fsc_pkg::S_EMIT;
            fsc_pkg::S_EMIT: begin
                if (emit_ok) n_state = last_h ? fsc_pkg::S_LOAD : fsc_pkg::S_READ;
            end
            default: n_state = fsc_pkg::S_LOAD;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_wr   = in_acc && !full;
        o_cmd.rd        = (r_state == fsc_pkg::S_READ);
        o_cmd.prep      = (r_state == fsc_pkg::S_PREP);
        o_cmd.rot       = (r_state == fsc_pkg::S_ROT);
        o_cmd.trig      = (r_state == fsc_pkg::S_TRIG);
        o_cmd.mac       = (r_state == fsc_pkg::S_MAC);
        o_cmd.clr_acc   = (in_acc && i_last) || (r_state == fsc_pkg::S_EMIT && emit_ok);
        o_cmd.div_load  = (r_state == fsc_pkg::S_DIVA || r_state == fsc_pkg::S_DIVB)
                          && r_step == '0;
        o_cmd.div_step  = (r_state == fsc_pkg::S_DIVA || r_state == fsc_pkg::S_DIVB)
                          && r_step != '0;
        o_cmd.div_sel_b = (r_state == fsc_pkg::S_DIVB);
        o_cmd.take_a    = (r_state == fsc_pkg::S_DIVB) && r_step == '0;
        o_cmd.take_b    = (r_state == fsc_pkg::S_SQA);
        o_cmd.sq_a      = (r_state == fsc_pkg::S_SQA);
        o_cmd.sq_b      = (r_state == fsc_pkg::S_SQB);
        o_cmd.emit      = (r_state == fsc_pkg::S_EMIT) && emit_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsc_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_run_ovf   <= 1'b0;
            r_out_valid <= 1'b0;
            r_m         <= '0;
            r_half      <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (i_last) begin
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                    r_run_ovf <= r_ovf || full;
                    r_m       <= cnt_inc;
                    r_half    <= cnt_inc >> 1;
                    r_j       <= '0;
                    r_k       <= '0;
                end else begin
                    r_count <= cnt_inc;
                    if (full) r_ovf <= 1'b1;
                end
            end
            if (r_state == fsc_pkg::S_PREP) r_step <= '0;
            else if (r_state == fsc_pkg::S_ROT && !rot_last) r_step <= r_step + 1'b1;
            else if (r_state == fsc_pkg::S_MAC) r_step <= '0;
            else if (r_state == fsc_pkg::S_DIVA || r_state == fsc_pkg::S_DIVB)
                r_step <= div_last ? '0 : r_step + 1'b1;
            if (r_state == fsc_pkg::S_MAC && !j_last) r_j <= r_j + 1'b1;
            if (r_state == fsc_pkg::S_EMIT && emit_ok) begin
                r_j <= '0;
                r_k <= r_k + 1'b1;
            end
            if (r_state == fsc_pkg::S_EMIT && emit_ok) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_stall   = (r_state != fsc_pkg::S_LOAD);
    assign o_valid   = r_out_valid;
    assign o_wr_addr = r_count[IDX_W-1:0];
    assign o_rd_addr = r_j;
    assign o_k       = r_k;
    assign o_iter    = r_step[3:0];
    assign o_m       = r_m;
    assign o_run_ovf = r_run_ovf;
    assign o_last_h  = last_h;

endmodule

@@ rtl/fsc_dp.sv @@
// Datapath: sample memory, iterative CORDIC, accumulators, divider, squares, result register.
// Uses fsc_pkg.
`timescale 1ns / 1ps

module fsc_dp #(
    parameter int MAX_SAMPLES = 128,
    parameter int CNT_W       = 8,
    parameter int IDX_W       = 7,
    parameter int ACC_W       = 39,
    parameter int NW          = 38
) (
    input  logic                    i_clk,
    input  fsc_pkg::t_dp_cmd        i_cmd,
    input  fsc_pkg::t_in_item       i_item,
    input  logic [IDX_W-1:0]        i_wr_addr,
    input  logic [IDX_W-1:0]        i_rd_addr,
    input  logic [fsc_pkg::K_W-1:0] i_k,
    input  logic [3:0]              i_iter,
    input  logic [CNT_W-1:0]        i_m,
    input  logic                    i_run_ovf,
    input  logic                    i_last_h,
    output fsc_pkg::t_out_item      o_item
);

    localparam int XW = fsc_pkg::XW;
    localparam int ZW = fsc_pkg::ZW;

    logic [31:0] mem [MAX_SAMPLES];
    logic [31:0] r_rd;

    logic [1:0]              r_quad;
    logic signed [XW-1:0]    r_x, r_y, dx, dy;
    logic signed [ZW-1:0]    r_z, at;
    logic signed [15:0]      r_ys, r_cv, r_sv;
    logic [15:0]             phase;
    logic signed [XW-1:0]    xr, yr;
    logic signed [19:0]      c20, s20;
    logic signed [31:0]      pc, ps;
    logic signed [ACC_W-1:0] r_acc_c, r_acc_s, dsrc;
    logic [NW-1:0]           r_num, mag;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W:0]          rem_sh;
    logic                    r_neg, geq;
    logic signed [31:0]      quo, r_a, r_b;
    logic signed [63:0]      r_sq_a, r_sq_b;
    logic [63:0]             pw_sum;
    fsc_pkg::t_out_item      r_out;

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) mem[i_wr_addr] <= {i_item.angle, i_item.sample};
        if (i_cmd.rd) r_rd <= mem[i_rd_addr];
    end

    // CORDIC
    assign phase = 16'((fsc_pkg::K_W+16)'(i_k) * (fsc_pkg::K_W+16)'(r_rd[31:16]));
    assign dx    = r_y >>> i_iter;
    assign dy    = r_x >>> i_iter;
    assign at    = signed'(ZW'(fsc_pkg::atan_turn(i_iter)));
    assign xr    = r_x + XW'(16384);
    assign yr    = r_y + XW'(16384);
    assign c20   = 20'(signed'(xr[XW-1:15]));
    assign s20   = 20'(signed'(yr[XW-1:15]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_quad <= phase[15:14];
            r_z    <= signed'({3'b000, phase[13:0], 16'h0000});
            r_x    <= fsc_pkg::CORDIC_KINIT;
            r_y    <= '0;
            r_ys   <= signed'(r_rd[15:0]);
        end else if (i_cmd.rot) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.trig) begin
            unique case (r_quad)
                2'd1: begin r_cv <= fsc_pkg::sat16(-s20); r_sv <= fsc_pkg::sat16(c20); end
                2'd2: begin r_cv <= fsc_pkg::sat16(-c20); r_sv <= fsc_pkg::sat16(-s20); end
                2'd3: begin r_cv <= fsc_pkg::sat16(s20);  r_sv <= fsc_pkg::sat16(-c20); end
                default: begin r_cv <= fsc_pkg::sat16(c20); r_sv <= fsc_pkg::sat16(s20); end
            endcase
        end
    end

    // multiply-accumulate
    assign pc = r_ys * r_cv;
    assign ps = r_ys * r_sv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc_c <= '0;
            r_acc_s <= '0;
        end else if (i_cmd.mac) begin
            r_acc_c <= r_acc_c + ACC_W'(pc);
            r_acc_s <= r_acc_s + ACC_W'(ps);
        end
    end

    // restoring divider, rounds half away from zero
    assign dsrc   = i_cmd.div_sel_b ? r_acc_s : r_acc_c;
    assign mag    = NW'(dsrc[ACC_W-1] ? -dsrc : dsrc) + NW'(i_m >> 1);
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign geq    = (rem_sh >= {1'b0, i_m});
    assign quo    = r_neg ? -signed'(r_num[31:0]) : signed'(r_num[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num <= mag;
            r_rem <= '0;
            r_neg <= dsrc[ACC_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= geq ? CNT_W'(rem_sh - {1'b0, i_m}) : rem_sh[CNT_W-1:0];
            r_num <= {r_num[NW-2:0], geq};
        end
        if (i_cmd.take_a) r_a <= quo;
        if (i_cmd.take_b) r_b <= quo;
        if (i_cmd.sq_a) r_sq_a <= r_a * r_a;
        if (i_cmd.sq_b) r_sq_b <= r_b * r_b;
    end

    // power and result register
    assign pw_sum = unsigned'(r_sq_a) + unsigned'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.harmonic_index     <= i_k;
            r_out.cosine_coefficient <= r_a;
            r_out.sine_coefficient   <= r_b;
            r_out.power              <= pw_sum[63] ? {63{1'b1}} : pw_sum[62:0];
            r_out.samples_dropped    <= i_run_ovf;
            r_out.last_harmonic      <= i_last_h;
        end
    end

    assign o_item = r_out;

endmodule

@@ rtl/fourier_series_coefficients_unit.sv @@
// Top level of the Fourier series coefficient unit: controller plus datapath.
// Uses fsc_pkg, fsc_ctrl, fsc_dp.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_item  (angle, sample, last_sample)
// output    out        o_valid / i_stall  o_item  (harmonic, a_k, b_k, power, flags)
//
// Loading accepts one item per cycle. After the item marked last, each harmonic
// runs per sample a memory read, setup, 16 CORDIC iterations, rounding and a
// MAC, then both coefficients in the shared restoring divider, then squares
// and the result register. The single CORDIC unit serves all samples in turn.
// Sync active-low reset returns to loading with an empty set; memories keep data.
// o_stall is high during the whole computation; a result held by i_stall holds
// the sequencer before the next result is loaded, also before the last one.

module fourier_series_coefficients_unit #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fsc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output fsc_pkg::t_out_item o_item
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int ACC_W = 32 + $clog2(MAX_SAMPLES);  // sum of m 16x16 products
    localparam int NW    = ACC_W - 1;                  // divider magnitude bits
    localparam int SW    = $clog2(NW + 1);

    fsc_pkg::t_dp_cmd        cmd;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [fsc_pkg::K_W-1:0] k;
    logic [3:0]              iter;
    logic [CNT_W-1:0]        m;
    logic                    run_ovf, last_h;

    fsc_ctrl #(
        .MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W), .IDX_W(IDX_W), .NW(NW), .SW(SW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_last    (i_item.last_sample),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (cmd),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_k       (k),
        .o_iter    (iter),
        .o_m       (m),
        .o_run_ovf (run_ovf),
        .o_last_h  (last_h)
    );

    fsc_dp #(
        .MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W), .IDX_W(IDX_W), .ACC_W(ACC_W), .NW(NW)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_item    (i_item),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .i_k       (k),
        .i_iter    (iter),
        .i_m       (m),
        .i_run_ovf (run_ovf),
        .i_last_h  (last_h),
        .o_item    (o_item)
    );

endmodule

@@ rtl/fsc_checker.sv @@
// Port-level checker for the Fourier series coefficient unit, bound to the top.
// Uses fsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input fsc_pkg::t_out_item o_item
);

    logic [fsc_pkg::K_W-1:0] r_exp_k;

    // expected harmonic number of the next delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_k <= '0;
        end else if (o_valid && !i_stall) begin
            r_exp_k <= o_item.last_harmonic ? '0 : o_item.harmonic_index + 1'b1;
        end
    end

    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "valid dropped")
    `ASSERT_NEXT(a_item_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_item), "item moved")
    `ASSERT_IMPLIES(a_k_seq, i_clk, i_rst_n, o_valid, o_item.harmonic_index == r_exp_k, "k order")
    `ASSERT_IMPLIES(a_pw_rng, i_clk, i_rst_n, o_valid, o_item.power[62] == 1'b0, "power range")

endmodule

bind fourier_series_coefficients_unit fsc_checker u_fsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
